### design/rmd160_pkg.sv
// shared constants, types and round tables for the ripemd-160 stream hasher
// depends on nothing
package rmd160_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned CountW     = 61;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  // request from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [31:0] w4;
    logic [31:0] w3;
    logic [31:0] w2;
    logic [31:0] w1;
    logic [31:0] w0;
  } digest_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] bool_fn(input logic [2:0] g, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    case (g)
      3'd0: return x ^ y ^ z;
      3'd1: return (x & y) | (~x & z);
      3'd2: return (x | ~y) ^ z;
      3'd3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic logic [31:0] add_l(input logic [2:0] g);
    case (g)
      3'd0: return 32'h00000000;
      3'd1: return 32'h5A827999;
      3'd2: return 32'h6ED9EBA1;
      3'd3: return 32'h8F1BBCDC;
      default: return 32'hA953FD4E;
    endcase
  endfunction

  function automatic logic [31:0] add_r(input logic [2:0] g);
    case (g)
      3'd0: return 32'h50A28BE6;
      3'd1: return 32'h5C4DD124;
      3'd2: return 32'h6D703EF3;
      3'd3: return 32'h7A6D76E9;
      default: return 32'h00000000;
    endcase
  endfunction

  localparam logic [3:0] SelL [80] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
    7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
    1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
  localparam logic [3:0] SelR [80] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
    6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
    8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
  localparam logic [4:0] RotL [80] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
    7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
    11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
  localparam logic [4:0] RotR [80] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
    9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
    15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};

endpackage

### design/rmd160_front.sv
// front part: takes input requests, drops idle ones, queues the rest
// depends on rmd160_pkg
module rmd160_front #(
  parameter int unsigned QueueDepth = rmd160_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rmd160_pkg::req_t   in_req_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output rmd160_pkg::req_t   q_req_o
);
  import rmd160_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop, useful;

  assign in_ready_o = (cnt_q != CntW'(QueueDepth));
  // idle requests carry nothing, so they are swallowed here
  assign useful     = in_req_i.valid | in_req_i.last;
  assign push       = in_valid_i & in_ready_o & useful;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

### design/rmd160_back.sv
// back part: block buffer, padding sequencer and one-round-per-cycle compression
// depends on rmd160_pkg
module rmd160_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  rmd160_pkg::req_t    q_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmd160_pkg::digest_t out_digest_o
);
  import rmd160_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_FINAL, S_OUT
  } state_e;

  state_e       state_q;
  logic [31:0]  buf_q [BlockBytes/4];  // message words, byte 0 of each word lowest
  logic [CountW-1:0] cnt_q;
  logic [5:0]   pos_q;       // padding write pointer
  logic         len_done_q;  // length already in current block
  logic         pad_last_q;  // last request seen, message still to be finished
  logic [6:0]   rnd_q;
  logic [31:0]  h_q [5];
  logic [31:0]  al_q, bl_q, cl_q, dl_q, el_q, ar_q, br_q, cr_q, dr_q, er_q;
  digest_t      dig_q;
  logic         ov_q;

  logic [63:0]  bits;
  logic [2:0]   grp;
  logic [31:0]  wl, wr, tl, tr;
  logic [3:0]   sl, sr;
  logic [6:0]   ri;

  assign bits = {cnt_q, 3'b000};
  assign ri   = (rnd_q < 7'd80) ? rnd_q : 7'd0;
  assign grp  = 3'(ri >> 4);
  assign sl   = SelL[ri];
  assign sr   = SelR[ri];
  assign wl   = buf_q[sl];
  assign wr   = buf_q[sr];
  assign tl   = rol32(al_q + bool_fn(grp, bl_q, cl_q, dl_q) + wl + add_l(grp), RotL[ri]) + el_q;
  assign tr   = rol32(ar_q + bool_fn(3'd4 - grp, br_q, cr_q, dr_q) + wr + add_r(grp),
                      RotR[ri]) + er_q;

  assign q_ready_o    = (state_q == S_IDLE);
  assign out_valid_o  = ov_q;
  assign out_digest_o = dig_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_req_i.valid) buf_q[cnt_q[5:2]][{cnt_q[1:0], 3'b000} +: 8] <= q_req_i.data;
        end
      end
      S_PAD: begin
        if (pos_q >= 6'd56 && len_done_q)
          buf_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= bits[{pos_q[2:0], 3'b000} +: 8];
        else if (pos_q == cnt_q[5:0] && !len_done_q && pad_last_q)
          buf_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= PadByte;
        else
          buf_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= 8'h00;
      end
      default: ;
    endcase
    if (state_q == S_ROUND) begin
      al_q <= el_q; el_q <= dl_q; dl_q <= rol32(cl_q, 5'd10); cl_q <= bl_q; bl_q <= tl;
      ar_q <= er_q; er_q <= dr_q; dr_q <= rol32(cr_q, 5'd10); cr_q <= br_q; br_q <= tr;
    end else begin
      al_q <= h_q[0]; bl_q <= h_q[1]; cl_q <= h_q[2]; dl_q <= h_q[3]; el_q <= h_q[4];
      ar_q <= h_q[0]; br_q <= h_q[1]; cr_q <= h_q[2]; dr_q <= h_q[3]; er_q <= h_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      pos_q      <= '0;
      len_done_q <= 1'b0;
      pad_last_q <= 1'b0;
      rnd_q      <= '0;
      h_q[0] <= Iv0; h_q[1] <= Iv1; h_q[2] <= Iv2; h_q[3] <= Iv3; h_q[4] <= Iv4;
      ov_q       <= 1'b0;
      dig_q      <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            pad_last_q <= q_req_i.last;
            rnd_q      <= '0;
            if (q_req_i.valid) begin
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q[5:0] == 6'd63) state_q <= S_ROUND;
              else if (q_req_i.last) begin
                state_q <= S_PAD;
                pos_q   <= cnt_q[5:0] + 1'b1;
              end
            end else begin
              state_q <= S_PAD;
              pos_q   <= cnt_q[5:0];
            end
            len_done_q <= 1'b0;
          end
        end
        S_PAD: begin
          // fill from pos_q to the end; length goes in if the 0x80 left room
          if (pos_q == 6'd63) begin
            state_q <= S_ROUND;
            rnd_q   <= '0;
            if (!len_done_q && cnt_q[5:0] < 6'd56) len_done_q <= 1'b1;
            if (!len_done_q && cnt_q[5:0] < 6'd56) begin
              state_q <= S_PAD;
              pos_q   <= 6'd56;
            end
          end else begin
            pos_q <= pos_q + 1'b1;
            if (!len_done_q && cnt_q[5:0] < 6'd56 && pos_q == 6'd55) begin
              len_done_q <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 7'(Rounds - 1)) state_q <= S_FINAL;
        end
        S_FINAL: begin
          h_q[1] <= h_q[2] + dl_q + er_q;
          h_q[2] <= h_q[3] + el_q + ar_q;
          h_q[3] <= h_q[4] + al_q + br_q;
          h_q[4] <= h_q[0] + bl_q + cr_q;
          h_q[0] <= h_q[1] + cl_q + dr_q;
          if (!pad_last_q) state_q <= S_IDLE;
          else if (!len_done_q) begin
            // long tail: second block holds zeros then the length
            // full block ending the message: 0x80 still to go at byte 0
            state_q    <= S_PAD;
            pos_q      <= '0;
            len_done_q <= (cnt_q[5:0] != 6'd0);
          end else state_q <= S_OUT;
        end
        S_OUT: begin
          if (!ov_q) begin
            ov_q  <= 1'b1;
            dig_q <= '{w4: h_q[4], w3: h_q[3], w2: h_q[2], w1: h_q[1], w0: h_q[0]};
            h_q[0] <= Iv0; h_q[1] <= Iv1; h_q[2] <= Iv2; h_q[3] <= Iv3; h_q[4] <= Iv4;
            cnt_q      <= '0;
            pad_last_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/ripemd160_stream_hasher_unit.sv
// top level of the ripemd-160 stream hasher
// depends on rmd160_pkg, rmd160_front and rmd160_back
//
// usage: one message byte per request on the s_axis channel. tdata[7:0] is the
// byte, tuser[0] says the byte is real (byte_valid), tlast ends the message.
// a request with tuser low and tlast high hashes an empty tail (empty message).
// requests with neither flag are idle and dropped by the front end.
// the front end holds a short queue so the sender keeps going while the
// back end compresses; the back end runs one double-line round per cycle.
// cost: the 64th byte of a block starts the 80 rounds and then the chaining
// update. a last request pads byte by byte, compresses once or twice,
// then shows the digest on m_axis.
// m_axis tdata carries the five chaining words, word 0 lowest; one request
// per message. the digest sits in an output register, so a stalled receiver
// only holds the back end once a further digest is ready.
// reset clears the queue, byte count and chaining words to the initial vector.
module ripemd160_stream_hasher_unit #(
  parameter int unsigned QueueDepth = rmd160_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte
  input  logic         s_axis_tuser,  // byte_valid
  input  logic         s_axis_tlast,  // last_of_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata   // digest_word0 .. digest_word4
);
  import rmd160_pkg::*;

  req_t    in_req, q_req;
  logic    q_valid, q_ready;
  digest_t dig;

  assign in_req = '{data: s_axis_tdata, valid: s_axis_tuser, last: s_axis_tlast};

  rmd160_front #(.QueueDepth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_req_i(in_req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  rmd160_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_digest_o(dig)
  );

  // packed struct has w0 in the low bits
  assign m_axis_tdata = dig;

endmodule
